/* design/udrb_pkg.sv */
package udrb_pkg;

	typedef enum logic [1:0] {
		CMD_RX_BYTE  = 2'd0,
		CMD_PUSH     = 2'd1,
		CMD_POP      = 2'd2,
		CMD_TX_READY = 2'd3
	} cmd_t;

	localparam logic [7:0] COUNT_MAX = 8'd255;

endpackage

/* design/uart_dual_ring_buffer_core.sv */
// Dual byte ring buffer for a serial port. It holds a receive ring, filled from the wire and
// drained by software pops, and a transmit ring, filled by software pushes and drained by
// transmitter-ready events. Each ring has RING_DEPTH slots and keeps one slot free, so it
// holds at most RING_DEPTH-1 bytes. Issue a request by raising start with cmd, data_byte and
// end_of_batch. The request is taken at a rising edge where start is high and busy is low.
// busy stays low, so a new request can follow in every cycle. Each request gives exactly one
// result in the next cycle, shown for a single cycle with done high. The receiver cannot stall
// the block: it must capture the result in that cycle. The result is registered, as the
// ring memories have a registered read port. A receive byte that finds the ring full is
// dropped and sets the sticky overflow flag, which only reset clears. A push that finds the
// transmit ring full is dropped, and so is every later push of the same send call, up to and
// including the one marked end_of_batch. Any push sets tx_irq_enable. A transmitter-ready event
// on an empty transmit ring clears it. rx_count saturates at 255. The ring memories need no
// clearing pass: a slot is read only after it has been written.
module uart_dual_ring_buffer_core #(
	parameter int RING_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  udrb_pkg::cmd_t    cmd,
	input  logic [7:0]        data_byte,
	input  logic              end_of_batch,
	output logic              done,
	output logic              accepted,
	output logic [7:0]        rx_byte,
	output logic              tx_valid,
	output logic [7:0]        tx_byte,
	output logic [7:0]        rx_count,
	output logic              overflow,
	output logic              tx_irq_enable
);
	import udrb_pkg::*;

	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W = PTR_W + 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RING_DEPTH);

	// ring storage, one write and one registered read per cycle each
	logic [7:0] rx_mem [RING_DEPTH];
	logic [7:0] tx_mem [RING_DEPTH];

	// ring pointers and flags
	logic [PTR_W-1:0] rx_head_q, rx_tail_q, tx_head_q, tx_tail_q;
	logic             overflow_q, irq_en_q, dropping_q;

	// result stage
	logic       done_s1, accepted_s1, pop_hit_s1, tx_valid_s1, overflow_s1, irq_en_s1;
	logic [7:0] rx_rdata_s1, tx_rdata_s1, rx_count_s1;

	// next-state logic
	logic             take;
	logic [PTR_W-1:0] rx_head_nx, rx_tail_nx, tx_head_nx, tx_tail_nx;
	logic [PTR_W-1:0] rx_head_inc, rx_tail_inc, tx_head_inc, tx_tail_inc;
	logic             rx_full, rx_empty, tx_full, tx_empty;
	logic             rx_wr, tx_wr, rx_rd, tx_rd;
	logic             overflow_nx, irq_en_nx, dropping_nx;
	logic [CNT_W-1:0] rx_cnt;
	logic [7:0]       rx_count_nx;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] idx);
		return (idx == PTR_LAST) ? '0 : idx + PTR_W'(1);
	endfunction

	// every request completes in the cycle after it is taken
	assign busy = 1'b0;
	assign take = start & ~busy;

	assign rx_head_inc = ring_next(rx_head_q);
	assign rx_tail_inc = ring_next(rx_tail_q);
	assign tx_head_inc = ring_next(tx_head_q);
	assign tx_tail_inc = ring_next(tx_tail_q);
	assign rx_full     = (rx_head_inc == rx_tail_q);
	assign tx_full     = (tx_head_inc == tx_tail_q);
	assign rx_empty    = (rx_head_q == rx_tail_q);
	assign tx_empty    = (tx_head_q == tx_tail_q);

	always_comb begin
		rx_wr       = 1'b0;
		tx_wr       = 1'b0;
		rx_rd       = 1'b0;
		tx_rd       = 1'b0;
		overflow_nx = overflow_q;
		irq_en_nx   = irq_en_q;
		dropping_nx = dropping_q;
		if (take) begin
			case (cmd)
				CMD_RX_BYTE: begin
					// store the wire byte, or drop it and flag the overflow
					if (rx_full) overflow_nx = 1'b1;
					else rx_wr = 1'b1;
				end
				CMD_PUSH: begin
					if (!dropping_q) begin
						if (tx_full) dropping_nx = 1'b1;
						else tx_wr = 1'b1;
					end
					irq_en_nx = 1'b1;
					// the last push of a send call ends drop mode
					if (end_of_batch) dropping_nx = 1'b0;
				end
				CMD_POP: begin
					rx_rd = ~rx_empty;
				end
				CMD_TX_READY: begin
					if (tx_empty) irq_en_nx = 1'b0;
					else tx_rd = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign rx_head_nx = rx_wr ? rx_head_inc : rx_head_q;
	assign rx_tail_nx = rx_rd ? rx_tail_inc : rx_tail_q;
	assign tx_head_nx = tx_wr ? tx_head_inc : tx_head_q;
	assign tx_tail_nx = tx_rd ? tx_tail_inc : tx_tail_q;

	// receive count after this request, saturated to eight bits
	always_comb begin
		if (rx_head_nx >= rx_tail_nx) begin
			rx_cnt = CNT_W'(rx_head_nx) - CNT_W'(rx_tail_nx);
		end else begin
			rx_cnt = CNT_W'(rx_head_nx) + DEPTH_C - CNT_W'(rx_tail_nx);
		end
		if (rx_cnt > CNT_W'(COUNT_MAX)) rx_count_nx = COUNT_MAX;
		else rx_count_nx = 8'(rx_cnt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q  <= '0;
			rx_tail_q  <= '0;
			tx_head_q  <= '0;
			tx_tail_q  <= '0;
			overflow_q <= 1'b0;
			irq_en_q   <= 1'b0;
			dropping_q <= 1'b0;
			done_s1    <= 1'b0;
		end else begin
			rx_head_q  <= rx_head_nx;
			rx_tail_q  <= rx_tail_nx;
			tx_head_q  <= tx_head_nx;
			tx_tail_q  <= tx_tail_nx;
			overflow_q <= overflow_nx;
			irq_en_q   <= irq_en_nx;
			dropping_q <= dropping_nx;
			done_s1    <= take;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		accepted_s1 <= rx_wr | tx_wr;
		pop_hit_s1  <= rx_rd;
		tx_valid_s1 <= tx_rd;
		overflow_s1 <= overflow_nx;
		irq_en_s1   <= irq_en_nx;
		rx_count_s1 <= rx_count_nx;
	end

	// memories: write at head, read at tail; one request touches one ring entry at most
	always_ff @(posedge clk) begin
		if (rx_wr) rx_mem[rx_head_q] <= data_byte;
		if (rx_rd) rx_rdata_s1 <= rx_mem[rx_tail_q];
	end

	always_ff @(posedge clk) begin
		if (tx_wr) tx_mem[tx_head_q] <= data_byte;
		if (tx_rd) tx_rdata_s1 <= tx_mem[tx_tail_q];
	end

	assign done          = done_s1;
	assign accepted      = accepted_s1;
	assign rx_byte       = pop_hit_s1 ? rx_rdata_s1 : 8'd0;
	assign tx_valid      = tx_valid_s1;
	assign tx_byte       = tx_valid_s1 ? tx_rdata_s1 : 8'd0;
	assign rx_count      = rx_count_s1;
	assign overflow      = overflow_s1;
	assign tx_irq_enable = irq_en_s1;

endmodule
